### rtl/flat_name_component_counter_assert.svh
// -----------------------------------------------------------------------------
// flat_name_component_counter_assert.svh
// Assertion macros used by the flat name component counter checker.
// -----------------------------------------------------------------------------
`ifndef FLAT_NAME_COMPONENT_COUNTER_ASSERT_SVH
`define FLAT_NAME_COMPONENT_COUNTER_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define FNCC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define FNCC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fncc_pkg.sv
// -----------------------------------------------------------------------------
// fncc_pkg
// Shared types and constants of the flat name component counter.
// -----------------------------------------------------------------------------
package fncc_pkg;

  localparam int BYTE_W     = 8;
  localparam int LOW_W      = 7;
  localparam int COUNT_W    = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_NON_MINIMAL = 2'd1,
    ERR_TOO_LONG    = 2'd2,
    ERR_TRUNCATED   = 2'd3
  } err_code_e;

  typedef enum logic {
    PH_DELIM = 1'b0,
    PH_DATA  = 1'b1
  } phase_e;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    logic [LOW_W-1:0] low7;      // length bits of a delimiter byte
    logic             cont;      // bit 7 set: delimiter continues
    logic             pad_lead;  // byte is exactly 0x80
    logic             last;      // final byte of the name
  } item_t;

endpackage

### rtl/fncc_front.sv
// -----------------------------------------------------------------------------
// fncc_front
// Input side: takes name bytes and classifies them into queue items.
// -----------------------------------------------------------------------------
module fncc_front import fncc_pkg::*; (
  input  logic              in_valid_i,
  input  logic [BYTE_W-1:0] name_byte_i,
  input  logic              final_byte_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output item_t             item_o
);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.low7     = name_byte_i[LOW_W-1:0];
    item_o.cont     = name_byte_i[BYTE_W-1];
    item_o.pad_lead = name_byte_i[BYTE_W-1] && (name_byte_i[LOW_W-1:0] == '0);
    item_o.last     = final_byte_i;
  end

endmodule

### rtl/fncc_queue.sv
// -----------------------------------------------------------------------------
// fncc_queue
// Short FIFO of classified items between the front and the back.
// -----------------------------------------------------------------------------
module fncc_queue import fncc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o
);

  item_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/fncc_back.sv
// -----------------------------------------------------------------------------
// fncc_back
// Parser: walks delimiters and data, counts components, holds the result.
// -----------------------------------------------------------------------------
module fncc_back import fncc_pkg::*; #(
  parameter int MAX_DELIM_BYTES = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  item_t              item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] component_count_o,
  output logic [1:0]         error_code_o
);

  localparam int LEN_W   = LOW_W * MAX_DELIM_BYTES;
  localparam int DSEEN_W = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;
  localparam logic [DSEEN_W:0] MAX_D = (DSEEN_W + 1)'(MAX_DELIM_BYTES);

  phase_e               phase_q, phase_d, phase_step;
  logic [DSEEN_W-1:0]   dseen_q, dseen_d, dseen_step;
  logic [LEN_W-1:0]     acc_q, acc_d;
  logic [LEN_W-1:0]     left_q, left_d, left_dec, len_new;
  logic [COUNT_W-1:0]   cnt_q, cnt_d, cnt_step;
  err_code_e            err_q, err_d, err_step, err_fin;
  logic                 out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]   count_q;
  err_code_e            code_q;

  logic blocked, act, data_done, too_long;
  logic ev_data, ev_nonmin, ev_cont_ok, ev_too_long, ev_end, count_inc, enter_data;
  logic finish;

  // Byte decode against the current parse position.
  always_comb begin
    blocked     = out_valid_q && out_stall_i;
    pop_o       = q_valid_i && !blocked;
    finish      = pop_o && item_i.last;
    act         = pop_o && (err_q == ERR_NONE);
    left_dec    = left_q - 1'b1;
    data_done   = (left_dec == '0);
    len_new     = LEN_W'({acc_q, item_i.low7});
    too_long    = (({1'b0, dseen_q} + 1'b1) >= MAX_D);
    ev_data     = act && (phase_q == PH_DATA);
    ev_nonmin   = act && (phase_q == PH_DELIM) && (dseen_q == '0) && item_i.pad_lead;
    ev_cont_ok  = act && (phase_q == PH_DELIM) && !ev_nonmin && item_i.cont && !too_long;
    ev_too_long = act && (phase_q == PH_DELIM) && !ev_nonmin && item_i.cont && too_long;
    ev_end      = act && (phase_q == PH_DELIM) && !item_i.cont;
    enter_data  = ev_end && (len_new != '0);
    count_inc   = (ev_data && data_done) || (ev_end && (len_new == '0));
  end

  // Phase next state.
  always_comb begin
    phase_step = phase_q;
    if (enter_data) begin
      phase_step = PH_DATA;
    end else if (ev_data && data_done) begin
      phase_step = PH_DELIM;
    end
    phase_d = finish ? PH_DELIM : phase_step;
  end

  // Length, count and error datapath.
  always_comb begin
    dseen_step = dseen_q;
    acc_d      = acc_q;
    left_d     = left_q;
    err_step   = err_q;
    cnt_step   = cnt_q;
    if (ev_data) begin
      left_d = left_dec;
    end
    if (ev_nonmin) begin
      err_step = ERR_NON_MINIMAL;
    end
    if (ev_too_long) begin
      err_step = ERR_TOO_LONG;
    end
    if (ev_cont_ok) begin
      acc_d      = len_new;
      dseen_step = dseen_q + 1'b1;
    end
    if (ev_end) begin
      acc_d      = '0;
      dseen_step = '0;
      if (enter_data) begin
        left_d = len_new;
      end
    end
    if (count_inc && (cnt_q != COUNT_MAX)) begin
      cnt_step = cnt_q + 1'b1;
    end

    err_fin = err_step;
    if ((err_step == ERR_NONE) && ((phase_step == PH_DATA) || (dseen_step != '0))) begin
      err_fin = ERR_TRUNCATED;
    end

    dseen_d = dseen_step;
    cnt_d   = cnt_step;
    err_d   = err_step;
    if (finish) begin
      dseen_d = '0;
      acc_d   = '0;
      left_d  = '0;
      cnt_d   = '0;
      err_d   = ERR_NONE;
    end

    out_valid_d = blocked ? 1'b1 : finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DELIM;
      dseen_q     <= '0;
      acc_q       <= '0;
      left_q      <= '0;
      cnt_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      dseen_q     <= dseen_d;
      acc_q       <= acc_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load only when a final byte retires.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      count_q <= cnt_step;
      code_q  <= err_fin;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign component_count_o = count_q;
  assign error_code_o      = code_q;

endmodule

### rtl/flat_name_component_counter.sv
// -----------------------------------------------------------------------------
// flat_name_component_counter
// Counts length-prefixed components of a flattened name, one byte per clock unless stalled.
// -----------------------------------------------------------------------------
// A flattened name streams in one byte per transaction, with final_byte_i
// high on its last byte. Each component is a big-endian base-128 length
// delimiter of up to MAX_DELIM_BYTES bytes followed by that many data bytes.
// One result transaction leaves per name, carrying the component count
// (saturating at 65535) and the first error met: non-minimal delimiter,
// delimiter too long, or truncated name. The block sustains one byte per
// clock while in_stall_o is low; a byte is registered in the item queue,
// then the parser updates its state and the result register from it, and
// the parser's per-byte state update is what sets the one-byte-per-clock
// figure. The two-entry queue lets input keep flowing while a result waits
// on out_stall_i; input stalls only once the queue fills.
// -----------------------------------------------------------------------------
module flat_name_component_counter import fncc_pkg::*; #(
  parameter int MAX_DELIM_BYTES = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [BYTE_W-1:0]  name_byte_i,
  input  logic               final_byte_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] component_count_o,
  output logic [1:0]         error_code_o
);

  logic  q_full, q_push, q_pop, q_valid;
  item_t front_item, back_item;

  // Front: accept and classify each byte.
  fncc_front u_front (
    .in_valid_i   (in_valid_i),
    .name_byte_i  (name_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (q_push),
    .item_o       (front_item)
  );

  // Hold classified bytes so the front keeps going while the back waits.
  fncc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  // Back: parse, count and drive the result register.
  fncc_back #(
    .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .item_i            (back_item),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .component_count_o (component_count_o),
    .error_code_o      (error_code_o)
  );

endmodule

### rtl/fncc_checker.sv
// -----------------------------------------------------------------------------
// fncc_checker
// Port-level checks of the flat name component counter, bound to the top.
// -----------------------------------------------------------------------------
`include "flat_name_component_counter_assert.svh"

module fncc_checker import fncc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [COUNT_W-1:0] component_count_o,
  input logic [1:0]         error_code_o
);

  // Stalled result holds.
  `FNCC_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(component_count_o) && $stable(error_code_o),
    "stalled result changed")

  // A clean name always closes at least one component.
  `FNCC_ASSERT(a_ok_nonzero, clk_i, rst_ni,
    out_valid_o && (error_code_o == ERR_NONE) |-> component_count_o != '0,
    "clean result with zero components")

  // With the output side free, the queue drains and input never stalls.
  `FNCC_ASSERT(a_no_stall, clk_i, rst_ni, !out_stall_i |=> !in_stall_o,
    "input stalled with free output")

  // Reset empties the queue and clears the result valid flag by the next edge.
  `FNCC_ASSERT_ALWAYS(a_reset, clk_i, !rst_ni |=> !out_valid_o && !in_stall_o,
    "state not cleared in reset")

endmodule

bind flat_name_component_counter fncc_checker u_fncc_checker (.*);
